FILE: rtl/palette_nearest_color_nibble_pack_defines.svh
// Assertion helpers shared by the RTL files.
`ifndef PALETTE_NEAREST_COLOR_NIBBLE_PACK_DEFINES_SVH
`define PALETTE_NEAREST_COLOR_NIBBLE_PACK_DEFINES_SVH

// Checked at every rising edge outside reset.
`define PNC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PNC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/pnc_pkg.sv
`timescale 1ns / 1ps
package pnc_pkg;

  localparam int COLOR_W             = 8;
  localparam int IDX_W               = 4;
  localparam int STORE_DEPTH         = 16;
  localparam int PALETTE_ENTRIES_DEF = 16;
  // Three squared 8-bit differences sum to at most 195075.
  localparam int DIST_W              = 18;
  localparam int BYTE_W              = 2 * IDX_W;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_PIXEL = 1'b1
  } pnc_action_e;

  // One word as it travels down the row of cells.
  typedef struct packed {
    logic               valid;
    logic               action;
    logic [IDX_W-1:0]   entry_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               row_end;
    logic [DIST_W-1:0]  best_dist;
    logic [IDX_W-1:0]   best_idx;
  } pnc_token_t;

endpackage

FILE: rtl/pnc_if.sv
`timescale 1ns / 1ps
interface pnc_in_if import pnc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [IDX_W-1:0]   entry_index;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic               row_end;

  modport source (
    output valid, action, entry_index, red, green, blue, row_end,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, red, green, blue, row_end,
    output ready
  );
endinterface

interface pnc_out_if import pnc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packed_byte;

  modport source (
    output valid, packed_byte,
    input  ready
  );
  modport sink (
    input  valid, packed_byte,
    output ready
  );
endinterface

FILE: rtl/pnc_cell.sv
`timescale 1ns / 1ps
`include "palette_nearest_color_nibble_pack_defines.svh"
module pnc_cell import pnc_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  pnc_token_t tok_i,
  output pnc_token_t tok_o
);

  logic [3*COLOR_W-1:0] pal_q, pal_d;
  pnc_token_t           tok_q, tok_d;

  logic [COLOR_W-1:0]   diff_r, diff_g, diff_b;
  logic [2*COLOR_W-1:0] sq_r, sq_g, sq_b;
  logic [DIST_W-1:0]    cand_dist;
  logic                 is_load, is_pixel;

  assign is_load  = tok_i.valid && (tok_i.action == ACT_LOAD) &&
                    (tok_i.entry_index == IDX_W'(CELL_IDX));
  assign is_pixel = tok_i.valid && (tok_i.action == ACT_PIXEL);

  always_comb begin
    diff_r = (tok_i.red > pal_q[3*COLOR_W-1:2*COLOR_W]) ?
             tok_i.red - pal_q[3*COLOR_W-1:2*COLOR_W] :
             pal_q[3*COLOR_W-1:2*COLOR_W] - tok_i.red;
    diff_g = (tok_i.green > pal_q[2*COLOR_W-1:COLOR_W]) ?
             tok_i.green - pal_q[2*COLOR_W-1:COLOR_W] :
             pal_q[2*COLOR_W-1:COLOR_W] - tok_i.green;
    diff_b = (tok_i.blue > pal_q[COLOR_W-1:0]) ?
             tok_i.blue - pal_q[COLOR_W-1:0] :
             pal_q[COLOR_W-1:0] - tok_i.blue;
    sq_r = (2*COLOR_W)'(diff_r) * (2*COLOR_W)'(diff_r);
    sq_g = (2*COLOR_W)'(diff_g) * (2*COLOR_W)'(diff_g);
    sq_b = (2*COLOR_W)'(diff_b) * (2*COLOR_W)'(diff_b);
    cand_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  end

  always_comb begin
    pal_d = pal_q;
    tok_d = tok_q;
    if (adv_i) begin
      // A load lands here as it passes, so words behind it see the new color.
      if (is_load) begin
        pal_d = {tok_i.red, tok_i.green, tok_i.blue};
      end
      tok_d = tok_i;
      // Strict compare keeps the lower index on a tie.
      if (is_pixel && (cand_dist < tok_i.best_dist)) begin
        tok_d.best_dist = cand_dist;
        tok_d.best_idx  = IDX_W'(CELL_IDX);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q <= '0;
      tok_q <= '0;
    end else begin
      pal_q <= pal_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

  `PNC_ASSERT(a_idx_bound, tok_q.valid |-> (tok_q.best_idx <= IDX_W'(CELL_IDX)), "best index beyond cell")
  `PNC_ASSERT(a_hold_on_stall, !adv_i |=> $stable(tok_q), "token moved while stalled")
  `PNC_ASSERT(a_dist_monotone, (adv_i && is_pixel) |=> (tok_q.best_dist <= $past(tok_i.best_dist)), "best distance grew")

endmodule

FILE: rtl/pnc_pack.sv
`timescale 1ns / 1ps
`include "palette_nearest_color_nibble_pack_defines.svh"
module pnc_pack import pnc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pnc_token_t        tok_i,
  input  logic              out_ready_i,
  output logic              adv_o,
  output logic              out_valid_o,
  output logic [BYTE_W-1:0] packed_byte_o
);

  logic              pending_q, pending_d;
  logic [IDX_W-1:0]  held_q, held_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              is_pixel;

  // The whole row moves whenever the output word is empty or being taken.
  assign adv_o    = !out_valid_q || out_ready_i;
  assign is_pixel = tok_i.valid && (tok_i.action == ACT_PIXEL);

  always_comb begin
    pending_d   = pending_q;
    held_d      = held_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    if (adv_o) begin
      out_valid_d = 1'b0;
      if (is_pixel) begin
        if (pending_q) begin
          out_valid_d = 1'b1;
          out_byte_d  = {held_q, tok_i.best_idx};
          pending_d   = 1'b0;
          held_d      = '0;
        end else if (tok_i.row_end) begin
          out_valid_d = 1'b1;
          out_byte_d  = {tok_i.best_idx, IDX_W'(0)};
        end else begin
          held_d    = tok_i.best_idx;
          pending_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pending_q   <= pending_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
  end

  assign out_valid_o   = out_valid_q;
  assign packed_byte_o = out_byte_q;

  `PNC_ASSERT(a_odd_row_end, (adv_o && is_pixel && !pending_q && tok_i.row_end) |=> (out_valid_q && (out_byte_q[IDX_W-1:0] == '0)), "odd row end byte has nonzero low nibble")
  `PNC_ASSERT(a_first_held, (adv_o && is_pixel && !pending_q && !tok_i.row_end) |=> (pending_q && !out_valid_q), "first pixel of pair not held")
  `PNC_ASSERT(a_pair_clears, (adv_o && is_pixel && pending_q) |=> (!pending_q && (held_q == '0) && out_valid_q), "pair did not emit and clear")

endmodule

FILE: rtl/palette_nearest_color_nibble_pack.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle; each palette slot is one cell of a row that a word
// walks through, one cell per cycle, and the whole row stalls only on output backpressure.
// Reset: asynchronous, active low; clears all palette entries to black, the held pixel
// and the output valid.
module palette_nearest_color_nibble_pack import pnc_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pnc_in_if.sink    pix_i,
  pnc_out_if.source byte_o
);

  pnc_token_t chain [PALETTE_ENTRIES+1];
  logic       adv;

  always_comb begin
    chain[0].valid       = pix_i.valid;
    chain[0].action      = pix_i.action;
    chain[0].entry_index = pix_i.entry_index;
    chain[0].red         = pix_i.red;
    chain[0].green       = pix_i.green;
    chain[0].blue        = pix_i.blue;
    chain[0].row_end     = pix_i.row_end;
    chain[0].best_dist   = '1;
    chain[0].best_idx    = '0;
  end

  for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
    pnc_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  pnc_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_i        (chain[PALETTE_ENTRIES]),
    .out_ready_i  (byte_o.ready),
    .adv_o        (adv),
    .out_valid_o  (byte_o.valid),
    .packed_byte_o(byte_o.packed_byte)
  );

  assign pix_i.ready = adv;

endmodule
